[rtl/afhc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afhc_pkg
// Shared types, constants and the crc-32c byte step for the activation file
// header checker.
// ----------------------------------------------------------------------------
package afhc_pkg;

  localparam int DefCountWidth = 64;

  // header layout
  localparam int HdrBytes = 40;
  localparam int HdrIdxW  = $clog2(HdrBytes);
  localparam int MagicLen = 8;

  localparam logic [7:0] MagicTag [MagicLen] = '{"G", "L", "M", "5", "X", "A", "C", "T"};

  localparam logic [31:0] HdrVersion = 32'd1;
  localparam logic [31:0] HdrSize    = 32'(HdrBytes);
  localparam logic [15:0] HdrDtype   = 16'd3;

  // crc-32c, reflected
  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CFG_EXP_TOKENS = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_EXP_HIDDEN = CfgIdxW'(1);

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TRUNCATED = 3'd1,
    STAT_BAD_MAGIC = 3'd2,
    STAT_VERSION   = 3'd3,
    STAT_EXTENT    = 3'd4,
    STAT_CRC       = 3'd5
  } status_e;

  // end-of-file request handed from the byte stage to the check stage
  typedef struct packed {
    logic        valid;
    logic [31:0] crc;
  } chk_t;

  function automatic logic [31:0] crc32c_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/afhc_ingest.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afhc_ingest
// Input register and per-byte stage: header capture, saturating byte count,
// running crc-32c, and the end-of-file snapshot for the check stage.
// ----------------------------------------------------------------------------
module afhc_ingest
  import afhc_pkg::*;
#(
  parameter int COUNT_WIDTH = DefCountWidth
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic [7:0]                       data_byte_i,
  input  wire logic                             last_byte_i,
  input  wire logic                             chk_ready_i,
  output      chk_t                             chk_o,
  output      logic [COUNT_WIDTH-1:0]           total_o,
  output      logic [HdrBytes-1:0][7:0]         hdr_o
);

  logic                     in_valid_q;
  logic [7:0]               data_q;
  logic                     last_q;
  logic [COUNT_WIDTH-1:0]   count_q, count_inc;
  logic [31:0]              crc_q, crc_d;
  logic [HdrBytes-1:0][7:0] hdr_q;
  logic                     chk_valid_q;
  logic [31:0]              chk_crc_q;
  logic [COUNT_WIDTH-1:0]   total_q;
  logic                     chk_free, a_adv, in_hdr;

  assign chk_free   = !chk_valid_q || chk_ready_i;
  // no byte moves while a finished file waits, so the header stays intact
  assign a_adv      = in_valid_q && chk_free;
  assign in_ready_o = !in_valid_q || a_adv;

  assign in_hdr    = count_q < COUNT_WIDTH'(HdrBytes);
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  assign crc_d     = in_hdr ? crc_q : crc32c_byte(crc_q, data_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      count_q     <= '0;
      crc_q       <= CrcInit;
      chk_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (a_adv) begin
        if (last_q) begin
          count_q <= '0;
          crc_q   <= CrcInit;
        end else begin
          count_q <= count_inc;
          crc_q   <= crc_d;
        end
      end
      if (chk_free) begin
        chk_valid_q <= a_adv && last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (a_adv && in_hdr) begin
      hdr_q[count_q[HdrIdxW-1:0]] <= data_q;
    end
    if (a_adv && last_q) begin
      total_q   <= count_inc;
      chk_crc_q <= crc_d;
    end
  end

  assign chk_o   = '{valid: chk_valid_q, crc: chk_crc_q};
  assign total_o = total_q;
  assign hdr_o   = hdr_q;

endmodule
`default_nettype wire

[rtl/afhc_judge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afhc_judge
// Check stage: evaluates the header of a finished file in priority order and
// loads the result register.
// ----------------------------------------------------------------------------
module afhc_judge
  import afhc_pkg::*;
#(
  parameter int COUNT_WIDTH = DefCountWidth
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire chk_t                     chk_i,
  input  wire logic [COUNT_WIDTH-1:0]   total_i,
  input  wire logic [HdrBytes-1:0][7:0] hdr_i,
  input  wire logic [31:0]              exp_tokens_i,
  input  wire logic [31:0]              exp_hidden_i,
  output      logic                     chk_ready_o,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic [2:0]               status_o,
  output      logic [31:0]              tok_count_o,
  output      logic [31:0]              hid_dim_o
);

  logic [31:0] tok, hid, version, hsize, crc_exp;
  logic [15:0] dtype, rsvd;
  logic [63:0] payload;
  logic [63:0] prod_q;
  logic [64:0] pay_end_q;
  logic        magic_ok, ver_bad, ext_bad, crc_bad, trunc, o_free;
  status_e     status_d;

  logic        out_valid_q;
  status_e     status_q;
  logic [31:0] tok_q, hid_q;

  assign tok     = hdr_i[19:16];
  assign hid     = hdr_i[23:20];
  assign version = hdr_i[11:8];
  assign hsize   = hdr_i[15:12];
  assign dtype   = hdr_i[25:24];
  assign rsvd    = hdr_i[27:26];
  assign payload = hdr_i[35:28];
  assign crc_exp = hdr_i[39:36];

  // these header fields settle well before the earliest possible last byte
  always_ff @(posedge clk_i) begin
    prod_q    <= {32'd0, tok} * {32'd0, hid};
    pay_end_q <= {1'b0, payload} + 65'(HdrBytes);
  end

  always_comb begin
    magic_ok = 1'b1;
    for (int i = 0; i < MagicLen; i++) begin
      if (hdr_i[i] != MagicTag[i]) magic_ok = 1'b0;
    end
  end

  assign trunc   = total_i < COUNT_WIDTH'(HdrBytes);
  assign ver_bad = (version != HdrVersion) || (hsize != HdrSize) ||
                   (dtype != HdrDtype) || (rsvd != 16'd0);
  assign ext_bad = (tok == 32'd0) || (hid == 32'd0) ||
                   ((exp_tokens_i != 32'd0) && (tok != exp_tokens_i)) ||
                   ((exp_hidden_i != 32'd0) && (hid != exp_hidden_i)) ||
                   prod_q[63] || (payload != {prod_q[62:0], 1'b0}) ||
                   pay_end_q[64] || (total_i == '1) ||
                   (65'(total_i) != pay_end_q);
  assign crc_bad = ~chk_i.crc != crc_exp;

  always_comb begin
    priority if (trunc)     status_d = STAT_TRUNCATED;
    else if (!magic_ok)     status_d = STAT_BAD_MAGIC;
    else if (ver_bad)       status_d = STAT_VERSION;
    else if (ext_bad)       status_d = STAT_EXTENT;
    else if (crc_bad)       status_d = STAT_CRC;
    else                    status_d = STAT_OK;
  end

  assign o_free      = !out_valid_q || out_ready_i;
  assign chk_ready_o = o_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_free) begin
      out_valid_q <= chk_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_i.valid && o_free) begin
      status_q <= status_d;
      tok_q    <= trunc ? 32'd0 : tok;
      hid_q    <= trunc ? 32'd0 : hid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign tok_count_o = tok_q;
  assign hid_dim_o   = hid_q;

endmodule
`default_nettype wire

[rtl/activation_file_header_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// activation_file_header_checker
// Streams a file one byte per request, keeps its 40-byte header and a crc-32c
// over the payload, and reports one status with the two header counts per file.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : data_byte_i / last_byte_i under in_valid_i / in_ready_o,
//                    one byte per request, last_byte_i set on the final byte
//   output channel : status_o, tok_count_o, hid_dim_o under
//                    out_valid_o / out_ready_i, one result per file
//   config channel : cfg_index_i / cfg_data_i under cfg_valid_i / cfg_ready_o,
//                    index 0 expected token count, 1 expected hidden size,
//                    other indexes ignored; write only while idle
//   throughput     : one byte per cycle while the check stage is not held up;
//                    crc byte step and saturating counter are combinational
//   result path    : the last byte, once accepted into the input register,
//                    passes the byte stage and then the check stage before
//                    the result shows on out_valid_o
//   reset          : byte count cleared, crc preset to all ones, expected
//                    counts zero; no clearing pass, ready right after reset
//   stall          : with the result register held by the receiver, bytes keep
//                    flowing until a second finished file waits behind it
// ----------------------------------------------------------------------------
module activation_file_header_checker
  import afhc_pkg::*;
#(
  parameter int COUNT_WIDTH = DefCountWidth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               last_byte_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [2:0]         status_o,
  output      logic [31:0]        tok_count_o,
  output      logic [31:0]        hid_dim_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  logic [31:0]              exp_tokens_q, exp_hidden_q;
  chk_t                     chk;
  logic                     chk_ready;
  logic [COUNT_WIDTH-1:0]   total;
  logic [HdrBytes-1:0][7:0] hdr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_tokens_q <= '0;
      exp_hidden_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EXP_TOKENS: exp_tokens_q <= cfg_data_i;
        CFG_EXP_HIDDEN: exp_hidden_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  afhc_ingest #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ingest (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .chk_ready_i (chk_ready),
    .chk_o       (chk),
    .total_o     (total),
    .hdr_o       (hdr)
  );

  afhc_judge #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_judge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chk_i        (chk),
    .total_i      (total),
    .hdr_i        (hdr),
    .exp_tokens_i (exp_tokens_q),
    .exp_hidden_i (exp_hidden_q),
    .chk_ready_o  (chk_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .tok_count_o  (tok_count_o),
    .hid_dim_o    (hid_dim_o)
  );

`ifndef ASSERT_OFF
  // a truncated file carries no counts
  a_trunc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_TRUNCATED) |->
      (tok_count_o == 32'd0) && (hid_dim_o == 32'd0))
    else $error("truncated result with nonzero counts");

  // an accepted file always has nonzero extents
  a_ok_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_OK) |->
      (tok_count_o != 32'd0) && (hid_dim_o != 32'd0))
    else $error("ok result with a zero count");

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && chk.valid)
    else $error("input stalled without a pending result");

  // a waiting end-of-file request is not dropped
  a_chk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk.valid && out_valid_o && !out_ready_i |=> chk.valid)
    else $error("pending check request lost");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams whole files through the activation file header checker, byte by
// byte, and compares every reported status and header count against an
// in-bench model of the header checks and the payload crc-32c. Directed
// files cover each status; random files are mostly well formed, with
// corrupted, resized, cut-short and noise files mixed in.
// ----------------------------------------------------------------------------
module tb_top;
  import afhc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_LO  = CFG_EXP_HIDDEN + 1'b1;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_TOP = '1;

  typedef struct packed {
    status_e     status;
    logic [31:0] tokens;
    logic [31:0] hidden;
  } verdict_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [7:0]         byte_data   = '0;
  logic               byte_last   = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [2:0]         status;
  logic [31:0]        tok_count;
  logic [31:0]        hid_dim;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [31:0]        cfg_data    = '0;

  // model state
  logic [7:0]  hdr_bytes [HdrBytes];
  logic [63:0] bytes_seen  = '0;
  logic [31:0] payload_crc = CrcInit;
  logic [31:0] want_tokens = '0;
  logic [31:0] want_hidden = '0;
  verdict_t    pending_verdicts [$];
  verdict_t    head;

  logic [7:0] file_q [$];
  int fail_count = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int cycles     = 0;
  int tx_mode    = 1;
  int rx_mode    = 1;
  bit hold_req   = 1'b0;
  int hold_left  = 0;
  int stall_left = 0;

  activation_file_header_checker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .data_byte_i (byte_data),
    .last_byte_i (byte_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .tok_count_o (tok_count),
    .hid_dim_o   (hid_dim),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = (r >> 1) ^ (CrcPoly & {32{r[0]}});
    return r;
  endfunction

  function automatic logic [63:0] hdr_field(int off, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v |= 64'(hdr_bytes[off + i]) << (8 * i);
    return v;
  endfunction

  // first failing check wins, in the order the block applies them
  function automatic verdict_t judge_file();
    verdict_t    v;
    logic [31:0] tok, hid;
    logic [63:0] plen, prod;
    bit          magic_ok;
    v.tokens = '0;
    v.hidden = '0;
    if (bytes_seen < 64'(HdrBytes)) begin
      v.status = STAT_TRUNCATED;
      return v;
    end
    tok  = 32'(hdr_field(16, 4));
    hid  = 32'(hdr_field(20, 4));
    plen = hdr_field(28, 8);
    prod = 64'(tok) * 64'(hid);
    v.tokens = tok;
    v.hidden = hid;
    magic_ok = 1'b1;
    for (int i = 0; i < MagicLen; i++) begin
      if (hdr_bytes[i] != MagicTag[i]) magic_ok = 1'b0;
    end
    if (!magic_ok) begin
      v.status = STAT_BAD_MAGIC;
    end else if (hdr_field(8, 4) != 64'(HdrVersion) || hdr_field(12, 4) != 64'(HdrSize) ||
                 hdr_field(24, 2) != 64'(HdrDtype) || hdr_field(26, 2) != 64'd0) begin
      v.status = STAT_VERSION;
    end else if (tok == 0 || hid == 0) begin
      v.status = STAT_EXTENT;
    end else if ((want_tokens != 0 && tok != want_tokens) ||
                 (want_hidden != 0 && hid != want_hidden)) begin
      v.status = STAT_EXTENT;
    end else if (prod > 64'h7FFF_FFFF_FFFF_FFFF || plen != {prod[62:0], 1'b0}) begin
      v.status = STAT_EXTENT;
    end else if (plen > 64'hFFFF_FFFF_FFFF_FFFF - 64'(HdrBytes)) begin
      v.status = STAT_EXTENT;
    end else if (bytes_seen == '1 || bytes_seen != plen + 64'(HdrBytes)) begin
      v.status = STAT_EXTENT;
    end else if (~payload_crc != 32'(hdr_field(36, 4))) begin
      v.status = STAT_CRC;
    end else begin
      v.status = STAT_OK;
    end
    return v;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic lst);
    if (bytes_seen < 64'(HdrBytes)) hdr_bytes[bytes_seen[5:0]] = b;
    else payload_crc = crc_step(payload_crc, b);
    if (bytes_seen != '1) bytes_seen++;
    if (lst) begin
      pending_verdicts.push_back(judge_file());
      bytes_seen  = '0;
      payload_crc = CrcInit;
    end
  endtask

  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge, returns at a falling edge with valid still up
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = pick_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    byte_data <= b;
    byte_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, lst);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  task automatic push_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  // header with the given fields, nbytes of random payload, crc of that payload
  task automatic build_file(input logic [31:0] tok, input logic [31:0] hid,
                            input logic [63:0] plen, input int nbytes);
    logic [31:0] crc;
    logic [7:0]  b;
    file_q.delete();
    for (int i = 0; i < MagicLen; i++) file_q.push_back(MagicTag[i]);
    push_le(64'(HdrVersion), 4);
    push_le(64'(HdrSize), 4);
    push_le(64'(tok), 4);
    push_le(64'(hid), 4);
    push_le(64'(HdrDtype), 2);
    push_le(64'd0, 2);
    push_le(plen, 8);
    push_le(64'd0, 4);
    crc = CrcInit;
    repeat (nbytes) begin
      b = 8'($urandom);
      file_q.push_back(b);
      crc = crc_step(crc, b);
    end
    crc = ~crc;
    for (int i = 0; i < 4; i++) file_q[36 + i] = crc[8*i +: 8];
  endtask

  task automatic build_good(input logic [31:0] tok, input logic [31:0] hid);
    build_file(tok, hid, 64'(tok) * 64'(hid) * 2, int'(tok * hid * 2));
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    release_input();
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_EXP_TOKENS) want_tokens = val;
    else if (idx == CFG_EXP_HIDDEN) want_hidden = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_file();
    logic [31:0] tok, hid;
    logic [63:0] plen;
    int pick, n;
    tok  = (want_tokens != 0) ? want_tokens : 32'($urandom_range(1, 4));
    hid  = (want_hidden != 0) ? want_hidden : 32'($urandom_range(1, 4));
    plen = 64'(tok) * 64'(hid) * 2;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      build_file(tok, hid, plen, int'(plen));
    end else if (pick < 68) begin
      build_file(tok, hid, plen, int'(plen));
      file_q[36 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    end else if (pick < 74) begin
      build_file(tok, hid, plen, int'(plen));
      n = $urandom_range(0, 35);
      file_q[n] ^= 8'($urandom_range(1, 255));
    end else if (pick < 84) begin
      n = $urandom_range(0, 1) ? int'(plen) - 1 : int'(plen) + $urandom_range(1, 3);
      build_file(tok, hid, plen, n);
    end else if (pick < 92) begin
      build_file(tok, hid, plen, int'(plen));
      n = $urandom_range(1, HdrBytes - 1);
      file_q = file_q[0:n-1];
    end else begin
      file_q.delete();
      n = $urandom_range(1, 60);
      repeat (n) file_q.push_back(8'($urandom));
    end
    send_file();
  endtask

  task automatic test_truncated();
    file_q = '{8'h00};
    send_file();
    file_q = '{8'hFF};
    send_file();
    build_good(1, 1);
    file_q = file_q[0:HdrBytes-2];
    send_file();
  endtask

  task automatic test_header_fields();
    build_good(1, 1);
    file_q[7] ^= 8'h20;
    send_file();
    build_good(1, 1);
    file_q[11] = 8'h80;
    send_file();
    build_good(1, 2);
    file_q[12] = 8'd41;
    send_file();
    build_good(2, 1);
    file_q[24] = 8'd2;
    send_file();
    build_good(1, 1);
    file_q[27] = 8'h01;
    send_file();
  endtask

  task automatic test_extent();
    build_file(0, 3, 0, 0);
    send_file();
    build_file(3, 0, 0, 0);
    send_file();
    build_file(2, 2, 9, 9);
    send_file();
    build_file(2, 2, 8, 7);
    send_file();
    build_file(2, 2, 8, 9);
    send_file();
    // product far beyond the 63-bit limit
    build_file('1, '1, '1, 0);
    send_file();
    // product just at the 63-bit limit, so header size plus payload overflows
    build_file(32'd2323823089, 32'd3969050863,
               64'd2323823089 * 64'd3969050863 * 2, 0);
    send_file();
  endtask

  task automatic test_crc_check();
    build_good(3, 2);
    send_file();
    build_good(3, 2);
    file_q[39] ^= 8'h80;
    send_file();
  endtask

  task automatic test_config_regs();
    wait_idle();
    write_reg(CFG_EXP_TOKENS, 32'd2);
    write_reg(CFG_EXP_HIDDEN, 32'd3);
    build_good(2, 3);
    send_file();
    build_good(3, 2);
    send_file();
    build_good(2, 4);
    send_file();
    wait_idle();
    // writes to unused indexes must leave both registers alone
    write_reg(CFG_UNUSED_LO, 32'd5);
    write_reg(CFG_UNUSED_TOP, 32'hFFFF_FFFF);
    build_good(2, 3);
    send_file();
    wait_idle();
    write_reg(CFG_EXP_TOKENS, '1);
    write_reg(CFG_EXP_HIDDEN, '1);
    build_file('1, '1, 0, 0);
    send_file();
    build_good(1, 1);
    send_file();
    wait_idle();
    write_reg(CFG_EXP_TOKENS, '0);
    write_reg(CFG_EXP_HIDDEN, '0);
  endtask

  task automatic test_input_stall();
    wait_idle();
    tx_mode  = 0;
    hold_req = 1'b1;
    repeat (20) begin
      file_q.delete();
      repeat ($urandom_range(1, 2)) file_q.push_back(8'($urandom));
      send_file();
    end
    build_good(2, 2);
    send_file();
    tx_mode = 1;
    wait_idle();
  endtask

  task automatic run_random_phase(input logic [31:0] tok_cfg, input logic [31:0] hid_cfg,
                                  input int tx_m, input int rx_m);
    int start_bytes, start_files;
    wait_idle();
    write_reg(CFG_EXP_TOKENS, tok_cfg);
    write_reg(CFG_EXP_HIDDEN, hid_cfg);
    tx_mode     = tx_m;
    rx_mode     = rx_m;
    start_bytes = bytes_sent;
    start_files = files_sent;
    while (bytes_sent - start_bytes < 24 || files_sent - start_files < 1) send_random_file();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 1, 1);
    run_random_phase(32'($urandom_range(1, 4)), 0, 0, 0);
    run_random_phase(0, 32'($urandom_range(1, 4)), 1, 0);
    run_random_phase(32'($urandom_range(1, 4)), 32'($urandom_range(1, 4)), 0, 1);
    tx_mode = 1;
    rx_mode = 1;
  endtask

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_mode != 0 && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        $display("%0t: result with none expected, status %0d tokens %0d hidden %0d",
                 $time, status, tok_count, hid_dim);
      end else begin
        head = pending_verdicts.pop_front();
        if (status !== head.status) begin
          fail_count++;
          $display("%0t: status expected %0d got %0d", $time, head.status, status);
        end
        if (tok_count !== head.tokens) begin
          fail_count++;
          $display("%0t: token count expected %0d got %0d", $time, head.tokens, tok_count);
        end
        if (hid_dim !== head.hidden) begin
          fail_count++;
          $display("%0t: hidden size expected %0d got %0d", $time, head.hidden, hid_dim);
        end
      end
    end
  end

  initial begin
    int drain;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_truncated();
    test_header_fields();
    test_extent();
    test_crc_check();
    test_config_regs();
    test_input_stall();
    test_random_traffic();
    release_input();
    drain = 0;
    while (pending_verdicts.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    while (pending_verdicts.size() != 0) begin
      head = pending_verdicts.pop_front();
      fail_count++;
      $display("%0t: missing result, expected status %0d tokens %0d hidden %0d",
               $time, head.status, head.tokens, head.hidden);
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[activation_file_header_checker.f]
rtl/afhc_pkg.sv
rtl/afhc_ingest.sv
rtl/afhc_judge.sv
rtl/activation_file_header_checker.sv
tb/tb_top.sv
